/* rtl/fcr_pkg.sv */
// Shared constants, types and datapath step functions for the Fresnel
// conductor reflectance pipeline. No dependencies.
package fcr_pkg;

  localparam int SQRT_STAGES = 16;   // 32 root bits, two per stage
  localparam int DIV_STAGES  = 10;   // 20 quotient bits, two per stage
  localparam int DIV_LAT     = DIV_STAGES + 1;

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [19:0] QUOT_CAP = 20'd262144;

  typedef enum logic [1:0] {
    ST_NORMAL   = 2'd0,
    ST_SAT      = 2'd1,
    ST_ZERO_DEN = 2'd2
  } status_t;

  typedef struct packed {
    logic [16:0] reflectance;
    status_t     status;
  } res_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [35:0] rem;
    logic [19:0] lo;
    logic [19:0] quo;
  } div_st_t;

  // one digit of a restoring square root
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [1:0] pair);
    logic [34:0] acc;
    logic [34:0] trial;
    sqrt_st_t    r;
    acc   = {s.rem[32:0], pair};
    trial = {1'b0, s.root, 2'b01};
    if (acc >= trial) begin
      r.rem  = acc - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = acc;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  // one bit of a restoring division
  function automatic div_st_t div_step(div_st_t s, logic [35:0] den);
    logic [36:0] acc;
    div_st_t     r;
    acc  = {s.rem, s.lo[19]};
    r.lo = {s.lo[18:0], 1'b0};
    if (acc >= {1'b0, den}) begin
      r.rem = 36'(acc - {1'b0, den});
      r.quo = {s.quo[18:0], 1'b1};
    end else begin
      r.rem = acc[35:0];
      r.quo = {s.quo[18:0], 1'b0};
    end
    return r;
  endfunction

endpackage

/* rtl/fcr_in_if.sv */
// Input channel: one spectral channel word per handshake.
// Depends on nothing.
interface fcr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cos_theta;
  logic        [15:0] eta_incident;
  logic        [15:0] eta_transmit;
  logic        [15:0] absorption;

  modport source (output valid, cos_theta, eta_incident, eta_transmit, absorption,
                  input ready);
  modport sink   (input valid, cos_theta, eta_incident, eta_transmit, absorption,
                  output ready);
endinterface

/* rtl/fcr_out_if.sv */
// Result channel: reflectance and status word per handshake.
// Depends on nothing.
interface fcr_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] reflectance;
  logic [1:0]  status;

  modport source (output valid, reflectance, status, input ready);
  modport sink   (input valid, reflectance, status, output ready);
endinterface

/* rtl/fcr_sqrt.sv */
// Pipelined 64-bit floor square root, two root bits per stage.
// Depends on fcr_pkg.
module fcr_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);

  fcr_pkg::sqrt_st_t st_r [fcr_pkg::SQRT_STAGES];
  logic [59:0]       v_r  [fcr_pkg::SQRT_STAGES];

  for (genvar g = 0; g < fcr_pkg::SQRT_STAGES; g++) begin : g_stage
    fcr_pkg::sqrt_st_t s_in;
    fcr_pkg::sqrt_st_t a;
    fcr_pkg::sqrt_st_t b;
    logic [63:0]       v_in;

    if (g == 0) begin : g_first
      assign s_in = '0;
      assign v_in = rad_i;
    end else begin : g_next
      assign s_in = st_r[g-1];
      assign v_in = {v_r[g-1], 4'b0};
    end

    always_comb begin
      a = fcr_pkg::sqrt_step(s_in, v_in[63:62]);
      b = fcr_pkg::sqrt_step(a, v_in[61:60]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g] <= b;
        v_r[g]  <= v_in[59:0];
      end
    end
  end

  assign root_o = st_r[fcr_pkg::SQRT_STAGES-1].root;

endmodule

/* rtl/fcr_div.sv */
// Pipelined restoring divider: (num << 16) / den, 20 quotient bits,
// cap_o when the quotient would not fit. Depends on fcr_pkg.
module fcr_div (
  input  logic        clk,
  input  logic        en,
  input  logic [35:0] num_i,
  input  logic [35:0] den_i,
  output logic [19:0] quo_o,
  output logic        cap_o
);

  fcr_pkg::div_st_t st_r  [fcr_pkg::DIV_LAT];
  logic [35:0]      den_r [fcr_pkg::DIV_LAT];
  logic             cap_r [fcr_pkg::DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0].rem <= {4'b0, num_i[35:4]};
      st_r[0].lo  <= {num_i[3:0], 16'b0};
      st_r[0].quo <= '0;
      den_r[0]    <= den_i;
      cap_r[0]    <= ({4'b0, num_i[35:4]} >= den_i);
    end
  end

  for (genvar g = 1; g < fcr_pkg::DIV_LAT; g++) begin : g_stage
    fcr_pkg::div_st_t a;
    fcr_pkg::div_st_t b;

    always_comb begin
      a = fcr_pkg::div_step(st_r[g-1], den_r[g-1]);
      b = fcr_pkg::div_step(a, den_r[g-1]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g]  <= b;
        den_r[g] <= den_r[g-1];
        cap_r[g] <= cap_r[g-1];
      end
    end
  end

  assign quo_o = st_r[fcr_pkg::DIV_LAT-1].quo;
  assign cap_o = cap_r[fcr_pkg::DIV_LAT-1];

endmodule

/* rtl/fresnel_conductor_reflectance_core.sv */
// Fresnel conductor reflectance core: one spectral channel word in, one
// reflectance word out, no state between words. A new word can enter every
// cycle while the output buffer is not full; a word shows on out_port after passing
// through 57 registers (13 arithmetic stages, two 16-stage square root units,
// an 11-stage divider pair and the output register). The
// whole pipeline advances together; a two-entry output buffer lets input
// continue while one result waits, and the pipe holds only once both are full.
// Depends on fcr_pkg, fcr_in_if, fcr_out_if, fcr_sqrt, fcr_div.
module fresnel_conductor_reflectance_core (
  input  logic           clk,
  input  logic           rst_n,
  fcr_in_if.sink         in_port,
  fcr_out_if.source      out_port
);

  typedef struct packed {
    logic        neg;
    logic [15:0] cmag;
    logic [15:0] e;
    logic [30:0] c2;
    logic [30:0] s2;
    logic [29:0] ce_sh;
    logic [29:0] s4e;
    logic [30:0] q0mag;
    logic        q0neg;
  } side1_t;

  typedef struct packed {
    logic        neg;
    logic [31:0] ce32;
    logic [30:0] s2;
    logic [32:0] t1;
    logic [32:0] t3;
  } side2_t;

  typedef struct packed {
    logic zero;
    logic sg1;
    logic sg2;
  } side3_t;

  function automatic logic [35:0] mag36(logic signed [35:0] x);
    return x[35] ? 36'(-x) : 36'(x);
  endfunction

  function automatic logic signed [19:0] sat_q(logic [19:0] q, logic cap, logic sg);
    logic [18:0] m;
    m = (cap || q > fcr_pkg::QUOT_CAP) ? fcr_pkg::QUOT_CAP[18:0] : q[18:0];
    return sg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  logic en;
  logic skid_v_r;
  logic out_v_r;
  fcr_pkg::res_t out_r, skid_r;

  assign en            = !skid_v_r;
  assign in_port.ready = en;

  // stage 1
  logic        v1_r, neg1_r;
  logic [15:0] cmag1_r, e1_r;
  logic [30:0] c21_r;
  logic [31:0] e21_r, n21_r, k21_r;
  logic [15:0] cmag_in;

  assign cmag_in = in_port.cos_theta[15] ? 16'(-in_port.cos_theta) : in_port.cos_theta;

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r  <= in_port.cos_theta[15];
      cmag1_r <= cmag_in;
      e1_r    <= in_port.eta_incident;
      c21_r   <= 31'(32'(cmag_in) * 32'(cmag_in));
      e21_r   <= 32'(in_port.eta_incident) * 32'(in_port.eta_incident);
      n21_r   <= 32'(in_port.eta_transmit) * 32'(in_port.eta_transmit);
      k21_r   <= 32'(in_port.absorption) * 32'(in_port.absorption);
    end
  end

  // stage 2
  logic        v2_r, neg2_r;
  logic [15:0] cmag2_r, e2_r;
  logic [30:0] c22_r, s22_r, s42_r;
  logic [31:0] e22_r, n22_r, k22_r, se2_r;
  logic [61:0] nk42_r;
  logic [29:0] ce2_r;
  logic [30:0] s2_1;

  assign s2_1 = 31'h4000_0000 - c21_r;

  always_ff @(posedge clk) begin
    if (en) begin
      neg2_r  <= neg1_r;
      cmag2_r <= cmag1_r;
      e2_r    <= e1_r;
      c22_r   <= c21_r;
      s22_r   <= s2_1;
      e22_r   <= e21_r;
      n22_r   <= n21_r;
      k22_r   <= k21_r;
      se2_r   <= 32'((64'(s2_1) * 64'(e21_r)) >> 30);
      nk42_r  <= 62'((64'(n21_r) * 64'(k21_r)) >> 2);
      ce2_r   <= 30'((64'(c21_r) * 64'(e21_r)) >> 32);
      s42_r   <= 31'((62'(s2_1) * 62'(s2_1)) >> 30);
    end
  end

  // stage 3
  logic               v3_r;
  side1_t             sd3_r;
  logic [61:0]        nk43_r;
  logic signed [34:0] dd;
  logic [34:0]        ddmag;

  always_comb begin
    dd    = $signed({3'b0, n22_r}) - $signed({3'b0, k22_r}) - $signed({3'b0, se2_r});
    ddmag = dd[34] ? 35'(-dd) : 35'(dd);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd3_r.neg   <= neg2_r;
      sd3_r.cmag  <= cmag2_r;
      sd3_r.e     <= e2_r;
      sd3_r.c2    <= c22_r;
      sd3_r.s2    <= s22_r;
      sd3_r.ce_sh <= ce2_r;
      sd3_r.s4e   <= 30'((64'(s42_r) * 64'(e22_r)) >> 32);
      sd3_r.q0mag <= ddmag[32:2];
      sd3_r.q0neg <= dd[34];
      nk43_r      <= nk42_r;
    end
  end

  // stage 4
  logic        v4_r;
  side1_t      sd4_r;
  logic [61:0] nk44_r, sq4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sd4_r  <= sd3_r;
      nk44_r <= nk43_r;
      sq4_r  <= 62'(sd3_r.q0mag) * 62'(sd3_r.q0mag);
    end
  end

  // stage 5
  logic        v5_r;
  side1_t      sd5_r;
  logic [63:0] rad5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sd5_r  <= sd4_r;
      rad5_r <= 64'(sq4_r) + 64'(nk44_r);
    end
  end

  // first root
  logic        va_r [fcr_pkg::SQRT_STAGES];
  side1_t      sa_r [fcr_pkg::SQRT_STAGES];
  logic [31:0] ab;

  fcr_sqrt u_sqrt_ab (.clk(clk), .en(en), .rad_i(rad5_r), .root_o(ab));

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r[0] <= sd5_r;
      for (int i = 1; i < fcr_pkg::SQRT_STAGES; i++) sa_r[i] <= sa_r[i-1];
    end
  end

  // stage 6
  side1_t      sa;
  logic [32:0] hsum;
  logic        v6_r, neg6_r;
  logic [31:0] h6_r, c2ab6_r, ce326_r;
  logic [32:0] t16_r;
  logic [30:0] s26_r;
  logic [29:0] s4e6_r;

  assign sa = sa_r[fcr_pkg::SQRT_STAGES-1];

  always_comb begin
    if (sa.q0neg) begin
      hsum = (ab >= 32'(sa.q0mag)) ? 33'(ab - 32'(sa.q0mag)) : 33'd0;
    end else begin
      hsum = 33'(ab) + 33'(sa.q0mag);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg6_r  <= sa.neg;
      h6_r    <= hsum[32:1];
      c2ab6_r <= 32'((64'(sa.c2) * 64'(ab)) >> 30);
      t16_r   <= 33'(ab) + 33'(sa.ce_sh);
      ce326_r <= 32'(sa.cmag) * 32'(sa.e);
      s26_r   <= sa.s2;
      s4e6_r  <= sa.s4e;
    end
  end

  // stage 7
  logic        v7_r;
  logic [31:0] h7_r;
  side2_t      sd7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      h7_r       <= h6_r;
      sd7_r.neg  <= neg6_r;
      sd7_r.ce32 <= ce326_r;
      sd7_r.s2   <= s26_r;
      sd7_r.t1   <= t16_r;
      sd7_r.t3   <= 33'(c2ab6_r) + 33'(s4e6_r);
    end
  end

  // second root
  logic        vb_r [fcr_pkg::SQRT_STAGES];
  side2_t      sb_r [fcr_pkg::SQRT_STAGES];
  logic [31:0] ah;
  side2_t      sb;

  fcr_sqrt u_sqrt_ah (.clk(clk), .en(en), .rad_i({32'b0, h7_r}), .root_o(ah));

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= sd7_r;
      for (int i = 1; i < fcr_pkg::SQRT_STAGES; i++) sb_r[i] <= sb_r[i-1];
    end
  end

  assign sb = sb_r[fcr_pkg::SQRT_STAGES-1];

  // stage 8
  logic        v8_r;
  side2_t      sd8_r;
  logic [33:0] m28_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sd8_r <= sb;
      m28_r <= 34'((49'(sb.ce32) * 49'(ah[16:0])) >> 15);
    end
  end

  // stage 9
  logic               v9_r, neg9_r;
  logic [33:0]        m49_r;
  logic [32:0]        t39_r;
  logic signed [35:0] d19_r, n19_r;
  logic signed [35:0] t1e, m2e;

  assign t1e = $signed({3'b0, sd8_r.t1});
  assign m2e = $signed({2'b0, m28_r});

  always_ff @(posedge clk) begin
    if (en) begin
      neg9_r <= sd8_r.neg;
      t39_r  <= sd8_r.t3;
      m49_r  <= 34'((65'(m28_r) * 65'(sd8_r.s2)) >> 30);
      d19_r  <= sd8_r.neg ? t1e - m2e : t1e + m2e;
      n19_r  <= sd8_r.neg ? t1e + m2e : t1e - m2e;
    end
  end

  // stage 10
  logic               v10_r;
  side3_t             sd10_r;
  logic [35:0]        nm1_r, dm1_r, nm2_r, dm2_r;
  logic signed [35:0] t3e, m4e, d2, n2;

  always_comb begin
    t3e = $signed({3'b0, t39_r});
    m4e = $signed({2'b0, m49_r});
    d2  = neg9_r ? t3e - m4e : t3e + m4e;
    n2  = neg9_r ? t3e + m4e : t3e - m4e;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd10_r.zero <= (d19_r == '0) || (d2 == '0);
      sd10_r.sg1  <= n19_r[35] ^ d19_r[35];
      sd10_r.sg2  <= n2[35] ^ d2[35];
      nm1_r       <= mag36(n19_r);
      dm1_r       <= mag36(d19_r);
      nm2_r       <= mag36(n2);
      dm2_r       <= mag36(d2);
    end
  end

  // dividers
  logic        vc_r [fcr_pkg::DIV_LAT];
  side3_t      sc_r [fcr_pkg::DIV_LAT];
  logic [19:0] q1, q2;
  logic        cap1, cap2;
  side3_t      sc;

  fcr_div u_div_rs (.clk(clk), .en(en), .num_i(nm1_r), .den_i(dm1_r),
                    .quo_o(q1), .cap_o(cap1));
  fcr_div u_div_fp (.clk(clk), .en(en), .num_i(nm2_r), .den_i(dm2_r),
                    .quo_o(q2), .cap_o(cap2));

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r[0] <= sd10_r;
      for (int i = 1; i < fcr_pkg::DIV_LAT; i++) sc_r[i] <= sc_r[i-1];
    end
  end

  assign sc = sc_r[fcr_pkg::DIV_LAT-1];

  // stage 11
  logic               v11_r, zero11_r;
  logic signed [19:0] rs11_r, fp11_r;

  always_ff @(posedge clk) begin
    if (en) begin
      zero11_r <= sc.zero;
      rs11_r   <= sat_q(q1, cap1, sc.sg1);
      fp11_r   <= sat_q(q2, cap2, sc.sg2);
    end
  end

  // stage 12
  logic               v12_r, zero12_r;
  logic signed [39:0] p12_r;
  logic signed [19:0] fp1;

  assign fp1 = 20'sd65536 + fp11_r;

  always_ff @(posedge clk) begin
    if (en) begin
      zero12_r <= zero11_r;
      p12_r    <= 40'(rs11_r) * 40'(fp1);
    end
  end

  // stage 13
  logic          v13_r;
  fcr_pkg::res_t res13_r, res;

  always_comb begin
    if (zero12_r) begin
      res.reflectance = fcr_pkg::ONE_Q16;
      res.status      = fcr_pkg::ST_ZERO_DEN;
    end else if (p12_r <= 0) begin
      res.reflectance = '0;
      res.status      = fcr_pkg::ST_NORMAL;
    end else if (p12_r[39:17] > 23'(fcr_pkg::ONE_Q16)) begin
      res.reflectance = fcr_pkg::ONE_Q16;
      res.status      = fcr_pkg::ST_SAT;
    end else begin
      res.reflectance = p12_r[33:17];
      res.status      = fcr_pkg::ST_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res13_r <= res;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
      v13_r <= 1'b0;
      for (int i = 0; i < fcr_pkg::SQRT_STAGES; i++) begin
        va_r[i] <= 1'b0;
        vb_r[i] <= 1'b0;
      end
      for (int i = 0; i < fcr_pkg::DIV_LAT; i++) vc_r[i] <= 1'b0;
    end else if (en) begin
      v1_r    <= in_port.valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      va_r[0] <= v5_r;
      for (int i = 1; i < fcr_pkg::SQRT_STAGES; i++) va_r[i] <= va_r[i-1];
      v6_r    <= va_r[fcr_pkg::SQRT_STAGES-1];
      v7_r    <= v6_r;
      vb_r[0] <= v7_r;
      for (int i = 1; i < fcr_pkg::SQRT_STAGES; i++) vb_r[i] <= vb_r[i-1];
      v8_r    <= vb_r[fcr_pkg::SQRT_STAGES-1];
      v9_r    <= v8_r;
      v10_r   <= v9_r;
      vc_r[0] <= v10_r;
      for (int i = 1; i < fcr_pkg::DIV_LAT; i++) vc_r[i] <= vc_r[i-1];
      v11_r   <= vc_r[fcr_pkg::DIV_LAT-1];
      v12_r   <= v11_r;
      v13_r   <= v12_r;
    end
  end

  // output register and skid word
  logic out_take;

  assign out_take = !out_v_r || out_port.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (out_take) begin
      out_v_r <= v13_r;
    end else if (v13_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (out_take) begin
      out_r <= res13_r;
    end else begin
      skid_r <= res13_r;
    end
  end

  assign out_port.valid       = out_v_r;
  assign out_port.reflectance = out_r.reflectance;
  assign out_port.status      = out_r.status;

endmodule

/* bench/tb_fresnel_conductor_reflectance_core.sv */
`timescale 1ns / 100ps
// Self-checking bench for fresnel_conductor_reflectance_core: directed and random
// channel words, a bit-exact reflectance predictor and an in-order result check.
// Depends on fcr_pkg, fcr_in_if, fcr_out_if and the core.
module tb_fresnel_conductor_reflectance_core;

  typedef struct packed {
    logic [15:0] cos_theta;
    logic [15:0] eta_incident;
    logic [15:0] eta_transmit;
    logic [15:0] absorption;
  } chan_word_t;

  localparam int N_RANDOM   = 1850;
  localparam int PHASE1_END = 640;
  localparam int PHASE2_END = 1280;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 100;

  logic clk;
  logic rst_n;

  fcr_in_if  in_if ();
  fcr_out_if out_if ();

  fresnel_conductor_reflectance_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_if),
    .out_port (out_if)
  );

  chan_word_t    pending_words[$];
  fcr_pkg::res_t expected_refl[$];
  int            words_sent;
  int            errors;
  int            idle_cycles;
  int            src_idle_pct;
  int            snk_idle_pct;

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint ratio_q16(input longint num, input longint den);
    longint q;
    q = (num * 65536) / den;
    if (q > 262144) q = 262144;
    if (q < -262144) q = -262144;
    return q;
  endfunction

  function automatic fcr_pkg::res_t reflectance_predict(input chan_word_t w);
    longint          c, q0, hsum, m2, m4, t1, t3, d1, d2, rs, fp, p;
    longint unsigned e, n, k, cmag, c2, s2, s4, e2, n2, k2, q0mag, ab, ah;
    longint unsigned m2mag, m4mag, refl;
    logic            neg;
    fcr_pkg::res_t   r;
    c = longint'($signed(w.cos_theta));
    e = w.eta_incident;
    n = w.eta_transmit;
    k = w.absorption;
    neg = c < 0;
    cmag = neg ? -c : c;
    c2 = cmag * cmag;
    s2 = (64'd1 << 30) - c2;
    s4 = (s2 * s2) >> 30;
    e2 = e * e;
    n2 = n * n;
    k2 = k * k;
    q0 = (longint'(n2) - longint'(k2) - longint'((s2 * e2) >> 30)) / 4;
    q0mag = (q0 < 0) ? -q0 : q0;
    ab = root_floor(q0mag * q0mag + (n2 * k2) / 4);
    hsum = longint'(ab) + q0;
    if (hsum < 0) hsum = 0;
    ah = root_floor(longint'(hsum) / 2);
    m2mag = (cmag * e * ah) >> 15;
    m4mag = (m2mag * s2) >> 30;
    m2 = neg ? -longint'(m2mag) : longint'(m2mag);
    m4 = neg ? -longint'(m4mag) : longint'(m4mag);
    t1 = longint'(ab + ((c2 * e2) >> 32));
    t3 = longint'(((c2 * ab) >> 30) + ((s4 * e2) >> 32));
    d1 = t1 + m2;
    d2 = t3 + m4;
    r.status = fcr_pkg::ST_NORMAL;
    if (d1 == 0 || d2 == 0) begin
      refl = 65536;
      r.status = fcr_pkg::ST_ZERO_DEN;
    end else begin
      rs = ratio_q16(t1 - m2, d1);
      fp = ratio_q16(t3 - m4, d2);
      p = rs * (65536 + fp);
      if (p <= 0) begin
        refl = 0;
      end else begin
        refl = longint'(p) >> 17;
        if (refl > 65536) begin
          refl = 65536;
          r.status = fcr_pkg::ST_SAT;
        end
      end
    end
    r.reflectance = refl[16:0];
    return r;
  endfunction

  function automatic logic [15:0] pick_field(input logic [15:0] hi);
    case ($urandom_range(5))
      0: return 16'd0;
      1: return hi;
      2: return 16'($urandom_range(8));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_word(input logic [15:0] c, input logic [15:0] e,
                          input logic [15:0] n, input logic [15:0] k);
    chan_word_t w;
    w.cos_theta    = c;
    w.eta_incident = (e == 16'd0) ? 16'd1 : e;
    w.eta_transmit = n;
    w.absorption   = k;
    pending_words.push_back(w);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      words_sent <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        chan_word_t w;
        w = pending_words.pop_front();
        in_if.valid        <= 1'b1;
        in_if.cos_theta    <= w.cos_theta;
        in_if.eta_incident <= w.eta_incident;
        in_if.eta_transmit <= w.eta_transmit;
        in_if.absorption   <= w.absorption;
        words_sent <= words_sent + 1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if (words_sent < PHASE1_END) begin
      src_idle_pct <= 10;
      snk_idle_pct <= 75;
    end else if (words_sent < PHASE2_END) begin
      src_idle_pct <= 75;
      snk_idle_pct <= 10;
    end else begin
      src_idle_pct <= 0;
      snk_idle_pct <= 0;
    end
  end

  // input acceptance feeds the predictor; output acceptance is checked
  always @(posedge clk) begin
    chan_word_t    w;
    fcr_pkg::res_t x;
    int            bad;
    bad = 0;
    if (!rst_n) begin
      errors <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        w.cos_theta    = in_if.cos_theta;
        w.eta_incident = in_if.eta_incident;
        w.eta_transmit = in_if.eta_transmit;
        w.absorption   = in_if.absorption;
        expected_refl.push_back(reflectance_predict(w));
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_refl.size() == 0) begin
          $error("unexpected result word: reflectance %0d status %0d",
                 out_if.reflectance, out_if.status);
          bad = bad + 1;
        end else begin
          x = expected_refl.pop_front();
          if (out_if.reflectance !== x.reflectance) begin
            $error("reflectance: expected %0d, actual %0d", x.reflectance,
                   out_if.reflectance);
            bad = bad + 1;
          end
          if (out_if.status !== x.status) begin
            $error("status: expected %0d, actual %0d", x.status, out_if.status);
            bad = bad + 1;
          end
        end
      end
      errors <= errors + bad;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;

    add_word(16'h7FFF, 16'd4096, 16'd600,   16'd14000);
    add_word(16'h8000, 16'd4096, 16'd600,   16'd14000);
    add_word(16'h0000, 16'd4096, 16'd6000,  16'd8000);
    add_word(16'hFFFF, 16'd4096, 16'd6000,  16'd8000);
    add_word(16'h0001, 16'd1,    16'd0,     16'd0);
    add_word(16'h0000, 16'd1,    16'd0,     16'd0);
    add_word(16'h7FFF, 16'hFFFF, 16'hFFFF,  16'hFFFF);
    add_word(16'h8000, 16'hFFFF, 16'hFFFF,  16'hFFFF);
    add_word(16'h4000, 16'hFFFF, 16'd0,     16'd0);
    add_word(16'h4000, 16'd1,    16'hFFFF,  16'd0);
    add_word(16'h4000, 16'd1,    16'd0,     16'hFFFF);
    add_word(16'h5A82, 16'd4096, 16'd4096,  16'd0);
    add_word(16'hC000, 16'd4096, 16'd2000,  16'd3000);
    add_word(16'h2000, 16'd6000, 16'd1000,  16'd100);
    add_word(16'h7FFF, 16'd4096, 16'd0,     16'd0);
    add_word(16'h0000, 16'hFFFF, 16'hFFFF,  16'd0);
    add_word(16'h0010, 16'd2,    16'd1,     16'd1);
    add_word(16'hAAAA, 16'h5555, 16'hAAAA,  16'h5555);
    add_word(16'h5555, 16'hAAAA, 16'h5555,  16'hAAAA);
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(3))
        0: add_word(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        1: add_word(16'($urandom_range(32767)), 16'($urandom_range(8192, 3000)),
                    16'($urandom_range(20000)), 16'($urandom_range(24000)));
        2: add_word(16'($urandom_range(32767)), 16'($urandom_range(6000, 4096)),
                    16'($urandom_range(4000)), 16'($urandom_range(40000)));
        default: add_word(pick_field(16'h7FFF) ^ ($urandom_range(1) ? 16'h8000 : 16'h0),
                          pick_field(16'hFFFF), pick_field(16'hFFFF),
                          pick_field(16'hFFFF));
      endcase
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_words.size() == 0);
    @(posedge clk);
    while (in_if.valid || expected_refl.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* fresnel_conductor_reflectance_core.f */
rtl/fcr_pkg.sv
rtl/fcr_in_if.sv
rtl/fcr_out_if.sv
rtl/fcr_sqrt.sv
rtl/fcr_div.sv
rtl/fresnel_conductor_reflectance_core.sv
bench/tb_fresnel_conductor_reflectance_core.sv
